### rtl/stt_pkg.sv
// stt_pkg: shared types, constants and byte-class helpers for the source text tokenizer.
// Used by stt_scan, source_text_tokenizer and stt_checker.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

	localparam int POS_W = 16;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam int NUM_KW = 5;
	localparam logic [NUM_KW-1:0] ALL_KW = '1;

	typedef enum logic [1:0] {
		M_IDLE   = 2'd0,
		M_WORD   = 2'd1,
		M_NUMBER = 2'd2,
		M_STRING = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		K_SYMBOL   = 3'd0,
		K_KEYWORD  = 3'd1,
		K_IDENT    = 3'd2,
		K_NUMBER   = 3'd3,
		K_STRING   = 3'd4,
		K_OPERATOR = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t       tok0;
		tok_t       tok1;
	} scan_res_t;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_PAD    = 8'h00;

	localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
		'{"f", "u", "n", "c", "t", "i", "o", "n"},
		'{"r", "e", "t", "u", "r", "n", CH_PAD, CH_PAD},
		'{"c", "o", "n", "s", "t", CH_PAD, CH_PAD, CH_PAD},
		'{"l", "e", "t", CH_PAD, CH_PAD, CH_PAD, CH_PAD, CH_PAD},
		'{"v", "a", "r", CH_PAD, CH_PAD, CH_PAD, CH_PAD, CH_PAD}
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd8, 4'd6, 4'd5, 4'd3, 4'd3};

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic is_symbol(input logic [7:0] c);
		return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
			(c == CH_RPAREN) || (c == CH_SEMI) || (c == CH_EQUAL);
	endfunction

	// Keywords that still agree with byte c at word offset k.
	function automatic logic [NUM_KW-1:0] kw_match(input logic [7:0] c,
		input logic [POS_W-1:0] k);
		logic [NUM_KW-1:0] m;
		for (int i = 0; i < NUM_KW; i++) begin
			m[i] = (k < POS_W'(KW_LEN[i])) && (KW_TEXT[i][k[2:0]] == c);
		end
		return m;
	endfunction

	function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

endpackage

`default_nettype wire

### rtl/stt_in_if.sv
// stt_in_if: request channel carrying text bytes and the end marker.
// Depends on nothing; handshake is valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

### rtl/stt_out_if.sv
// stt_out_if: request channel carrying token descriptors.
// Depends on nothing; handshake is valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface stt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/stt_scan.sv
// stt_scan: scanner state registers and the per-byte next-state / token logic.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_scan (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          text_byte,
	input  wire logic                end_of_text,
	output stt_pkg::scan_res_t       res
);

	stt_pkg::mode_t                    mode_q, mode_n;
	logic                              quote_q, quote_n;
	logic [stt_pkg::POS_W-1:0]         begin_q, begin_n;
	logic [stt_pkg::POS_W-1:0]         pos_q, pos_n;
	logic [stt_pkg::NUM_KW-1:0]        cand_q, cand_n;

	logic [stt_pkg::POS_W-1:0]         pos_inc, k_cur;
	logic                              pos_sat;
	logic [stt_pkg::NUM_KW-1:0]        len_hit;
	stt_pkg::tok_t                     close_tok, str_tok, idle_tok;
	logic                              idle_emit, closing, run_idle;
	logic [7:0]                        quote_ch;

	always_comb begin
		pos_sat = (pos_q == stt_pkg::POS_MAX);
		pos_inc = pos_sat ? pos_q : pos_q + 1'b1;
		k_cur   = (pos_q >= begin_q) ? pos_q - begin_q : '0;
		for (int i = 0; i < stt_pkg::NUM_KW; i++) begin
			len_hit[i] = (k_cur == stt_pkg::POS_W'(stt_pkg::KW_LEN[i]));
		end
		quote_ch = quote_q ? stt_pkg::CH_SQUOTE : stt_pkg::CH_DQUOTE;

		close_tok.kind   = (mode_q != stt_pkg::M_WORD) ? stt_pkg::K_NUMBER :
			(|(cand_q & len_hit)) ? stt_pkg::K_KEYWORD : stt_pkg::K_IDENT;
		close_tok.start  = stt_pkg::sat16(begin_q);
		close_tok.length = stt_pkg::sat16(k_cur);
		close_tok.last   = 1'b0;

		str_tok.kind   = stt_pkg::K_STRING;
		str_tok.start  = stt_pkg::sat16(begin_q);
		str_tok.length = stt_pkg::sat16(k_cur);
		str_tok.last   = 1'b0;

		idle_emit = !stt_pkg::is_space(text_byte) && !stt_pkg::is_alpha(text_byte) &&
			!stt_pkg::is_digit(text_byte) && (text_byte != stt_pkg::CH_UNDER) &&
			(text_byte != stt_pkg::CH_DQUOTE) && (text_byte != stt_pkg::CH_SQUOTE);
		idle_tok.kind   = stt_pkg::is_symbol(text_byte) ? stt_pkg::K_SYMBOL :
			stt_pkg::K_OPERATOR;
		idle_tok.start  = stt_pkg::sat16(pos_q);
		idle_tok.length = 16'd1;
		idle_tok.last   = 1'b0;
	end

	always_comb begin
		res.count = 2'd0;
		res.tok0  = '0;
		res.tok1  = '0;
		mode_n    = mode_q;
		quote_n   = quote_q;
		begin_n   = begin_q;
		pos_n     = pos_inc;
		cand_n    = cand_q;
		closing   = 1'b0;
		run_idle  = 1'b0;

		if (end_of_text) begin
			if (mode_q == stt_pkg::M_WORD || mode_q == stt_pkg::M_NUMBER) begin
				res.count = 2'd1;
				res.tok0  = close_tok;
			end else if (mode_q == stt_pkg::M_STRING) begin
				res.count = 2'd1;
				res.tok0  = str_tok;
			end
			mode_n  = stt_pkg::M_IDLE;
			quote_n = 1'b0;
			begin_n = '0;
			pos_n   = '0;
			cand_n  = stt_pkg::ALL_KW;
		end else begin
			case (mode_q)
				stt_pkg::M_WORD: begin
					if (stt_pkg::is_alpha(text_byte) || stt_pkg::is_digit(text_byte) ||
						text_byte == stt_pkg::CH_UNDER) begin
						cand_n = pos_sat ? '0 : (cand_q & stt_pkg::kw_match(text_byte, k_cur));
					end else begin
						closing  = 1'b1;
						run_idle = 1'b1;
					end
				end
				stt_pkg::M_NUMBER: begin
					if (!stt_pkg::is_digit(text_byte)) begin
						closing  = 1'b1;
						run_idle = 1'b1;
					end
				end
				stt_pkg::M_STRING: begin
					if (text_byte == quote_ch) begin
						res.count = 2'd1;
						res.tok0  = str_tok;
						mode_n    = stt_pkg::M_IDLE;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase

			if (closing) begin
				res.count = 2'd1;
				res.tok0  = close_tok;
				mode_n    = stt_pkg::M_IDLE;
			end

			if (run_idle) begin
				if (stt_pkg::is_alpha(text_byte) || text_byte == stt_pkg::CH_UNDER) begin
					mode_n  = stt_pkg::M_WORD;
					begin_n = pos_q;
					cand_n  = pos_sat ? '0 : stt_pkg::kw_match(text_byte, '0);
				end else if (stt_pkg::is_digit(text_byte)) begin
					mode_n  = stt_pkg::M_NUMBER;
					begin_n = pos_q;
				end else if (text_byte == stt_pkg::CH_DQUOTE ||
					text_byte == stt_pkg::CH_SQUOTE) begin
					mode_n  = stt_pkg::M_STRING;
					quote_n = (text_byte == stt_pkg::CH_SQUOTE);
					begin_n = pos_inc;
				end else if (idle_emit) begin
					if (closing) begin
						res.count = 2'd2;
						res.tok1  = idle_tok;
					end else begin
						res.count = 2'd1;
						res.tok0  = idle_tok;
					end
				end
			end
		end

		if (res.count == 2'd1) begin
			res.tok0.last = 1'b1;
		end else if (res.count == 2'd2) begin
			res.tok1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stt_pkg::M_IDLE;
			quote_q <= 1'b0;
			begin_q <= '0;
			pos_q   <= '0;
			cand_q  <= stt_pkg::ALL_KW;
		end else if (step) begin
			mode_q  <= mode_n;
			quote_q <= quote_n;
			begin_q <= begin_n;
			pos_q   <= pos_n;
			cand_q  <= cand_n;
		end
	end

endmodule

`default_nettype wire

### rtl/source_text_tokenizer.sv
// A byte's first token is presented after its request is taken and has passed the
// input register and then the result register.
// Throughput: one byte per cycle while the output is not stalled; a byte that yields two
// tokens holds the result register until both tokens have been taken.
// Reset clears the scanner to idle at offset 0 and empties both registers.
// source_text_tokenizer: top level; depends on stt_pkg, stt_in_if, stt_out_if, stt_scan.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer (
	input  wire logic clk,
	input  wire logic arst_n,
	stt_in_if.sink    text_in,
	stt_out_if.source token_out
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               end_s1;
	stt_pkg::scan_res_t res;
	logic               advance, buf_free, out_fire;

	stt_pkg::tok_t      r0_q, r1_q, head_tok;
	logic [1:0]         cnt_q;
	logic               head_q;

	stt_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.text_byte   (byte_s1),
		.end_of_text (end_s1),
		.res         (res)
	);

	assign out_fire       = token_out.valid && token_out.ready;
	assign buf_free       = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && token_out.ready);
	assign advance        = valid_s1 && ((res.count == 2'd0) || buf_free);
	assign text_in.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.valid && text_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			byte_s1 <= text_in.text_byte;
			end_s1  <= text_in.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			head_q <= 1'b0;
		end else if (advance && res.count != 2'd0) begin
			cnt_q  <= res.count;
			head_q <= 1'b0;
		end else if (out_fire) begin
			cnt_q  <= cnt_q - 2'd1;
			head_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.count != 2'd0) begin
			r0_q <= res.tok0;
			r1_q <= res.tok1;
		end
	end

	assign head_tok               = head_q ? r1_q : r0_q;
	assign token_out.valid        = (cnt_q != 2'd0);
	assign token_out.token_kind   = head_tok.kind;
	assign token_out.token_start  = head_tok.start;
	assign token_out.token_length = head_tok.length;
	assign token_out.last_of_run  = head_tok.last;

endmodule

`default_nettype wire

### rtl/stt_checker.sv
// stt_checker: port-level assertions on the tokenizer output channel, bound to the top.
// Depends on stt_pkg and source_text_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module stt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  token_kind,
	input wire logic [15:0] token_start,
	input wire logic [15:0] token_length,
	input wire logic        last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
		$stable(token_start) && $stable(token_length) && $stable(last_of_run))
		else $error("stalled token changed");

	a_single_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == stt_pkg::K_SYMBOL || token_kind == stt_pkg::K_OPERATOR)
		|-> token_length == 16'd1)
		else $error("symbol or operator token not one byte");

	a_kw_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == stt_pkg::K_KEYWORD |->
		(token_length == 16'd3 || token_length == 16'd5 || token_length == 16'd6 ||
		token_length == 16'd8))
		else $error("keyword with impossible length");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("second token of a request missing");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (token_out.valid),
	.out_ready    (token_out.ready),
	.token_kind   (token_out.token_kind),
	.token_start  (token_out.token_start),
	.token_length (token_out.token_length),
	.last_of_run  (token_out.last_of_run)
);

`default_nettype wire

### tb/tb_source_text_tokenizer.sv
`timescale 1ns / 1ps
// tb_source_text_tokenizer: self-checking bench for the source text tokenizer, with its own
// scanner model, random byte/token stimulus and random stalls on both channels.
// Depends on stt_pkg, stt_in_if, stt_out_if and the source_text_tokenizer RTL.

module tb_source_text_tokenizer;

	typedef logic [stt_pkg::POS_W-1:0] pos_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       eot;
	} text_req_t;

	localparam logic [63:0] KW_WORDS [stt_pkg::NUM_KW] =
		'{"function", "return", "const", "let", "var"};
	localparam int KW_LENS [stt_pkg::NUM_KW] = '{8, 6, 5, 3, 3};
	localparam logic [7:0] SYM_BYTES [6] = '{stt_pkg::CH_LBRACE, stt_pkg::CH_RBRACE,
		stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_SEMI, stt_pkg::CH_EQUAL};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_eot = 1'b0;
	logic       out_ready = 1'b0;
	logic       hold_off = 1'b0;
	logic       steady = 1'b0;
	int         gap_left = 0;
	int         stall_left = 0;
	int         accepted = 0;
	int         mismatches = 0;

	text_req_t      text_queue[$];
	stt_pkg::tok_t  tokens_due[$];

	// scanner model state
	stt_pkg::mode_t            lx_mode;
	logic                      lx_single;
	pos_t                      lx_begin;
	pos_t                      lx_pos;
	logic [stt_pkg::NUM_KW-1:0] lx_cand;
	stt_pkg::tok_t             step_toks[2];
	int                        step_n;

	stt_in_if  text_in();
	stt_out_if token_out();

	assign text_in.valid = in_valid;
	assign text_in.text_byte = in_byte;
	assign text_in.end_of_text = in_eot;
	assign token_out.ready = out_ready;

	source_text_tokenizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in),
		.token_out(token_out)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic blank_c(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic letter_c(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic digit_c(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic word_c(input logic [7:0] c);
		return letter_c(c) || digit_c(c) || c == stt_pkg::CH_UNDER;
	endfunction

	function automatic logic sym_c(input logic [7:0] c);
		return c == stt_pkg::CH_LBRACE || c == stt_pkg::CH_RBRACE ||
			c == stt_pkg::CH_LPAREN || c == stt_pkg::CH_RPAREN ||
			c == stt_pkg::CH_SEMI || c == stt_pkg::CH_EQUAL;
	endfunction

	function automatic pos_t bump(input pos_t p);
		return (p == stt_pkg::POS_MAX) ? p : p + 1'b1;
	endfunction

	function automatic pos_t span(input pos_t from, input pos_t to);
		return (to >= from) ? to - from : '0;
	endfunction

	function automatic logic [15:0] clip16(input pos_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [7:0] kw_byte(input int i, input int k);
		return KW_WORDS[i][(KW_LENS[i] - 1 - k) * 8 +: 8];
	endfunction

	function void lex_reset();
		lx_mode = stt_pkg::M_IDLE;
		lx_single = 1'b0;
		lx_begin = '0;
		lx_pos = '0;
		lx_cand = '1;
	endfunction

	function void emit_token(input stt_pkg::kind_t k, input pos_t s, input pos_t l);
		step_toks[step_n].kind = k;
		step_toks[step_n].start = clip16(s);
		step_toks[step_n].length = clip16(l);
		step_toks[step_n].last = 1'b0;
		step_n++;
	endfunction

	function void word_byte(input logic [7:0] c);
		pos_t k;
		k = span(lx_begin, lx_pos);
		if (lx_pos == stt_pkg::POS_MAX) begin
			lx_cand = '0;
		end else begin
			for (int i = 0; i < stt_pkg::NUM_KW; i++) begin
				if (k >= pos_t'(KW_LENS[i]) || kw_byte(i, int'(k)) != c)
					lx_cand[i] = 1'b0;
			end
		end
	endfunction

	function void close_run();
		pos_t           len;
		stt_pkg::kind_t k;
		len = span(lx_begin, lx_pos);
		k = stt_pkg::K_NUMBER;
		if (lx_mode == stt_pkg::M_WORD) begin
			k = stt_pkg::K_IDENT;
			for (int i = 0; i < stt_pkg::NUM_KW; i++) begin
				if (lx_cand[i] && len == pos_t'(KW_LENS[i]))
					k = stt_pkg::K_KEYWORD;
			end
		end
		emit_token(k, lx_begin, len);
		lx_mode = stt_pkg::M_IDLE;
	endfunction

	function void open_token(input logic [7:0] c);
		if (blank_c(c)) begin
		end else if (sym_c(c)) begin
			emit_token(stt_pkg::K_SYMBOL, lx_pos, pos_t'(1));
		end else if (letter_c(c) || c == stt_pkg::CH_UNDER) begin
			lx_mode = stt_pkg::M_WORD;
			lx_begin = lx_pos;
			lx_cand = '1;
			word_byte(c);
		end else if (digit_c(c)) begin
			lx_mode = stt_pkg::M_NUMBER;
			lx_begin = lx_pos;
		end else if (c == stt_pkg::CH_DQUOTE || c == stt_pkg::CH_SQUOTE) begin
			lx_mode = stt_pkg::M_STRING;
			lx_single = (c == stt_pkg::CH_SQUOTE);
			lx_begin = bump(lx_pos);
		end else begin
			emit_token(stt_pkg::K_OPERATOR, lx_pos, pos_t'(1));
		end
	endfunction

	// tokens caused by one accepted request, appended to tokens_due
	function void lex_step(input logic [7:0] c, input logic eot);
		step_n = 0;
		if (eot) begin
			if (lx_mode == stt_pkg::M_WORD || lx_mode == stt_pkg::M_NUMBER)
				close_run();
			else if (lx_mode == stt_pkg::M_STRING)
				emit_token(stt_pkg::K_STRING, lx_begin, span(lx_begin, lx_pos));
			lex_reset();
		end else begin
			case (lx_mode)
				stt_pkg::M_WORD: begin
					if (word_c(c)) begin
						word_byte(c);
					end else begin
						close_run();
						open_token(c);
					end
				end
				stt_pkg::M_NUMBER: begin
					if (!digit_c(c)) begin
						close_run();
						open_token(c);
					end
				end
				stt_pkg::M_STRING: begin
					if (c == (lx_single ? stt_pkg::CH_SQUOTE : stt_pkg::CH_DQUOTE)) begin
						emit_token(stt_pkg::K_STRING, lx_begin, span(lx_begin, lx_pos));
						lx_mode = stt_pkg::M_IDLE;
					end
				end
				default: open_token(c);
			endcase
			lx_pos = bump(lx_pos);
		end
		for (int i = 0; i < step_n; i++) begin
			step_toks[i].last = (i == step_n - 1);
			tokens_due = {tokens_due, step_toks[i]};
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function void put(input logic [7:0] c);
		text_req_t r;
		r.text_byte = c;
		r.eot = 1'b0;
		text_queue = {text_queue, r};
	endfunction

	function void put_end();
		text_req_t r;
		r.text_byte = 8'($urandom_range(0, 255));
		r.eot = 1'b1;
		text_queue = {text_queue, r};
	endfunction

	function void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? 8'h41 + c : 8'h61 + c;
	endfunction

	function automatic logic [7:0] rand_word_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return rand_letter();
		if (r < 9)
			return 8'h30 + 8'($urandom_range(0, 9));
		return stt_pkg::CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
	endfunction

	function void put_token();
		int         sel;
		int         n;
		int         w;
		logic [7:0] q;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 16) begin
			// keyword, or a near miss: one short or one longer
			w = $urandom_range(0, stt_pkg::NUM_KW - 1);
			n = $urandom_range(0, 3);
			for (int k = 0; k < KW_LENS[w]; k++) begin
				if (!(n == 2 && k == KW_LENS[w] - 1))
					put(kw_byte(w, k));
			end
			if (n == 3)
				put(rand_word_char());
		end else if (sel < 30) begin
			put($urandom_range(0, 1) ? rand_letter() : stt_pkg::CH_UNDER);
			n = $urandom_range(0, 6);
			for (int k = 0; k < n; k++)
				put(rand_word_char());
		end else if (sel < 42) begin
			n = $urandom_range(1, 5);
			for (int k = 0; k < n; k++)
				put(8'h30 + 8'($urandom_range(0, 9)));
		end else if (sel < 54) begin
			q = $urandom_range(0, 1) ? stt_pkg::CH_SQUOTE : stt_pkg::CH_DQUOTE;
			put(q);
			n = $urandom_range(0, 5);
			for (int k = 0; k < n; k++) begin
				c = 8'($urandom_range(0, 255));
				put((c == q) ? 8'h20 : c);
			end
			if ($urandom_range(0, 9) != 0)
				put(q);
		end else if (sel < 66) begin
			put(SYM_BYTES[$urandom_range(0, 5)]);
		end else if (sel < 74) begin
			do
				c = 8'($urandom_range(0, 255));
			while (blank_c(c) || word_c(c) || sym_c(c) || c == stt_pkg::CH_SQUOTE ||
				c == stt_pkg::CH_DQUOTE);
			put(c);
		end else if (sel < 88) begin
			n = $urandom_range(1, 3);
			for (int k = 0; k < n; k++)
				put(rand_blank());
		end else if (sel < 93) begin
			put_end();
		end else begin
			put(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: token mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		text_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			in_eot <= 1'b0;
		end else begin
			if (in_valid && text_in.ready) begin
				lex_step(in_byte, in_eot);
				accepted++;
			end
			if (!in_valid || text_in.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (text_queue.size() != 0) begin
					req = text_queue.pop_front();
					in_byte <= req.text_byte;
					in_eot <= req.eot;
					in_valid <= 1'b1;
					gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// token monitor and ready generation
	always @(posedge clk or negedge arst_n) begin
		stt_pkg::tok_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (token_out.valid && out_ready) begin
				if (tokens_due.size() == 0) begin
					report_mismatch("token with nothing expected");
				end else begin
					want = tokens_due.pop_front();
					if (token_out.token_kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d",
							token_out.token_kind, want.kind));
					if (token_out.token_start !== want.start)
						report_mismatch($sformatf("start %0d, expected %0d",
							token_out.token_start, want.start));
					if (token_out.token_length !== want.length)
						report_mismatch($sformatf("length %0d, expected %0d",
							token_out.token_length, want.length));
					if (token_out.last_of_run !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b",
							token_out.last_of_run, want.last));
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// stretches without idling on either side
	always @(posedge clk) begin
		if ($urandom_range(0, 149) == 0)
			steady <= ~steady;
	end

	// long output stall while requests keep coming
	initial begin
		wait (accepted >= 120);
		hold_off <= 1'b1;
		repeat (90) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		lex_reset();
		put_text("const");
		put(8'hFF);
		put_text("9;'a\"'\"\"");
		put(8'h00);
		put(8'h09);
		put_text("_9)\"ab");
		put_end();
		put_end();
		while (text_queue.size() < 475) begin
			put_token();
			if ($urandom_range(0, 9) < 4)
				put(rand_blank());
		end
		put_end();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
